/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/swx_pkg.sv */
// Shared types and constants for the seeded xorshift byte whitener.
// No dependencies; imported by the top level, controller, datapath, checker and testbench.
package swx_pkg;

  typedef enum logic [1:0] {
    FUNC_RESEED = 2'd0,
    FUNC_MIX    = 2'd1,
    FUNC_BYTE   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  localparam logic [63:0] SEED_INIT = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD   = 64'd1442695040888963407;
  localparam logic [63:0] XS_MUL    = 64'h2545_F491_4F6C_DD1D;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take last_of_run from the input port
    logic load_mix;  // xor value into seeds, swapped for the cross coupling
    logic reseed;    // use the initial seeds for load_mix
    logic xshift;    // xorshift step on seed A
    logic mul_ll;    // partial product lo x lo
    logic mul_hl;    // partial product hi x lo
    logic mul_lh;    // partial product lo x hi
    logic sel_b;     // multiplicand is seed B
    logic use_xs;    // constant is the xorshift multiplier
    logic wb_lcg;    // selected seed <= product + increment
    logic wb_word;   // word <= product[63:32]
    logic emit;      // load output register, advance word and phase
  } swx_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic phase_zero;
    logic out_free;
  } swx_sts_t;

endpackage

/* rtl/seeded_xorshift_byte_whitener.sv */
// Next-byte, phase 1..3: accept, emit, then the byte in the output register. Phase 0:
// accept with the xorshift step, three 32x32 partial products, writeback, emit. Input
// stalls until the emit; output stalls delay the emit. Reseed and mix: input stalled for
// four LCG passes (three partial products and a writeback each) on one shared 32x32
// multiplier; unused code: no stall. Reset (async, active low): seed A to its initial
// value; seed B, word, phase, out valid, state cleared; acc, last, byte not reset.
module seeded_xorshift_byte_whitener (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] value_i,
  input  logic        last_of_run_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  random_byte_o,
  output logic        last_out_o
);
  import swx_pkg::*;

  swx_cmd_t cmd;
  swx_sts_t sts;

  swx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swx_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .last_of_run_i (last_of_run_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .random_byte_o (random_byte_o),
    .last_out_o    (last_out_o)
  );

endmodule

/* rtl/swx_ctrl.sv */
// Sequencer for the whitener: input handshake and multiply schedule.
// Depends on swx_pkg.
module swx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        func_i,
  output logic              in_stall_o,
  input  swx_pkg::swx_sts_t sts_i,
  output swx_pkg::swx_cmd_t cmd_o
);
  import swx_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL0 = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_WB   = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic       xs_q, xs_d;
  logic [1:0] pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      xs_q    <= 1'b0;
      pass_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      xs_q    <= xs_d;
      pass_q  <= pass_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    xs_d         = xs_q;
    pass_d       = pass_q;
    cmd_o        = '0;
    cmd_o.sel_b  = pass_q[0] && !xs_q;
    cmd_o.use_xs = xs_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          pass_d        = 2'd0;
          unique case (func_e'(func_i))
            FUNC_RESEED: begin
              cmd_o.load_mix = 1'b1;
              cmd_o.reseed   = 1'b1;
              xs_d           = 1'b0;
              state_d        = S_MUL0;
            end
            FUNC_MIX: begin
              cmd_o.load_mix = 1'b1;
              xs_d           = 1'b0;
              state_d        = S_MUL0;
            end
            FUNC_BYTE: begin
              if (sts_i.phase_zero) begin
                cmd_o.xshift = 1'b1;
                xs_d         = 1'b1;
                state_d      = S_MUL0;
              end else begin
                state_d = S_EMIT;
              end
            end
            FUNC_NONE: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MUL0: begin
        cmd_o.mul_ll = 1'b1;
        state_d      = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_hl = 1'b1;
        state_d      = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_lh = 1'b1;
        state_d      = S_WB;
      end
      S_WB: begin
        if (xs_q) begin
          cmd_o.wb_word = 1'b1;
          state_d       = S_EMIT;
        end else begin
          cmd_o.wb_lcg = 1'b1;
          pass_d       = pass_q + 2'd1;
          state_d      = (pass_q == 2'd3) ? S_IDLE : S_MUL0;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/swx_dp.sv */
// Datapath: seeds, word buffer, byte phase, shared 32x32 multiplier
// and the output register. Depends on swx_pkg.
module swx_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       value_i,
  input  logic              last_of_run_i,
  input  swx_pkg::swx_cmd_t cmd_i,
  output swx_pkg::swx_sts_t sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        random_byte_o,
  output logic              last_out_o
);
  import swx_pkg::*;

  logic [63:0] seed_a_q, seed_a_d;
  logic [63:0] seed_b_q, seed_b_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] acc_q, acc_d;
  logic        last_q;
  logic [7:0]  byte_q;
  logic        last_out_q;

  logic [63:0] xs1, xs2, xs3;
  logic [63:0] opnd, kmul;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] lcg_res;

  always_comb begin
    xs1 = seed_a_q ^ (seed_a_q >> 12);
    xs2 = xs1 ^ (xs1 << 25);
    xs3 = xs2 ^ (xs2 >> 27);
  end

  assign opnd    = cmd_i.sel_b ? seed_b_q : seed_a_q;
  assign kmul    = cmd_i.use_xs ? XS_MUL : LCG_MUL;
  assign mul_a   = cmd_i.mul_hl ? opnd[63:32] : opnd[31:0];
  assign mul_b   = cmd_i.mul_lh ? kmul[63:32] : kmul[31:0];
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign lcg_res = acc_q + LCG_ADD;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_ll) begin
      acc_d = prod;
    end else if (cmd_i.mul_hl || cmd_i.mul_lh) begin
      acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end
  end

  always_comb begin
    seed_a_d    = seed_a_q;
    seed_b_d    = seed_b_q;
    word_d      = word_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_mix) begin
      // seed A chain starts from B^v and vice versa
      seed_a_d = (cmd_i.reseed ? 64'd0 : seed_b_q) ^ value_i;
      seed_b_d = (cmd_i.reseed ? SEED_INIT : seed_a_q) ^ value_i;
    end
    if (cmd_i.xshift) begin
      seed_a_d = xs3;
    end
    if (cmd_i.wb_lcg) begin
      if (cmd_i.sel_b) begin
        seed_b_d = lcg_res;
      end else begin
        seed_a_d = lcg_res;
      end
    end
    if (cmd_i.wb_word) begin
      word_d = acc_q[63:32];
    end
    if (cmd_i.emit) begin
      word_d      = {8'd0, word_q[31:8]};
      phase_d     = last_q ? 2'd0 : phase_q + 2'd1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q    <= SEED_INIT;
      seed_b_q    <= 64'd0;
      word_q      <= 32'd0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      seed_a_q    <= seed_a_d;
      seed_b_q    <= seed_b_d;
      word_q      <= word_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.capture) begin
      last_q <= last_of_run_i;
    end
    if (cmd_i.emit) begin
      byte_q     <= word_q[7:0];
      last_out_q <= last_q;
    end
  end

  assign sts_o.phase_zero = (phase_q == 2'd0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign random_byte_o = byte_q;
  assign last_out_o    = last_out_q;

endmodule

/* rtl/swx_chk.sv */
// Port-level checker for the whitener, bound to the top level.
// Depends on swx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swx_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  func_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  random_byte_o,
  input logic        last_out_o
);
  import swx_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `SWX_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(random_byte_o) && $stable(last_out_o))
  `SWX_ASSERT_NXT(a_busy_after_acc, clk_i, rst_ni, in_acc && (func_i != FUNC_NONE), in_stall_o)
  `SWX_ASSERT_NXT(a_mix_no_byte, clk_i, rst_ni, in_acc && ((func_i == FUNC_RESEED) || (func_i == FUNC_MIX)), !$rose(out_valid_o))
  `SWX_ASSERT_IMP(a_byte_while_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind seeded_xorshift_byte_whitener swx_chk u_chk (.*);

/* tb/whitener_scoreboard.sv */
// Scoreboard for the seeded xorshift byte whitener: tracks seeds, word and phase
// from accepted input transactions and checks every output byte in order.
// Depends on swx_pkg for the func_e codes.
module whitener_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [63:0] value_i,
  input  logic        last_of_run_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  random_byte_i,
  input  logic        last_out_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import swx_pkg::*;

  localparam logic [63:0] KEY_A_INIT = 64'd18446744073709551557;
  localparam logic [63:0] MMIX_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] MMIX_INC   = 64'd1442695040888963407;
  localparam logic [63:0] STAR_MUL   = 64'h2545_F491_4F6C_DD1D;

  typedef struct packed {
    logic [7:0] rnd;
    logic       last;
  } byte_txn_t;

  byte_txn_t   expected_bytes[$];
  logic [63:0] key_a;
  logic [63:0] key_b;
  logic [31:0] rand_word;
  logic [1:0]  byte_idx;

  function automatic logic [63:0] mmix_lcg(input logic [63:0] v);
    return v * MMIX_MUL + MMIX_INC;
  endfunction

  // Cross-coupled: each key comes from the other one.
  task automatic fold_value(input logic [63:0] v);
    logic [63:0] xa;
    logic [63:0] xb;
    xa = key_a ^ v;
    xb = key_b ^ v;
    key_a = mmix_lcg(mmix_lcg(xb));
    key_b = mmix_lcg(mmix_lcg(xa));
  endtask

  task automatic next_byte(input logic last);
    logic [63:0] x;
    logic [63:0] prod;
    if (byte_idx == 2'd0) begin
      x = key_a;
      x = x ^ (x >> 12);
      x = x ^ (x << 25);
      x = x ^ (x >> 27);
      key_a = x;
      prod = x * STAR_MUL;
      rand_word = prod[63:32];
    end
    expected_bytes.push_back('{rnd: rand_word[7:0], last: last});
    rand_word = rand_word >> 8;
    byte_idx = last ? 2'd0 : byte_idx + 2'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    byte_txn_t want;
    if (!rst_ni) begin
      key_a = KEY_A_INIT;
      key_b = '0;
      rand_word = '0;
      byte_idx = '0;
      expected_bytes.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transaction: byte %h last %b", $time,
                   random_byte_i, last_out_i);
          fail_count_o++;
        end else begin
          want = expected_bytes.pop_front();
          if (random_byte_i !== want.rnd) begin
            $display("%0t: random_byte expected %h actual %h", $time, want.rnd,
                     random_byte_i);
            fail_count_o++;
          end
          if (last_out_i !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last,
                     last_out_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (func_e'(func_i))
          FUNC_RESEED: begin
            key_a = KEY_A_INIT;
            key_b = '0;
            fold_value(value_i);
          end
          FUNC_MIX:  fold_value(value_i);
          FUNC_BYTE: next_byte(last_of_run_i);
          default: ;
        endcase
      end
      pending_o = expected_bytes.size();
    end
  end

endmodule

/* tb/seeded_xorshift_byte_whitener_tb.sv */
// Top-level bench for seeded_xorshift_byte_whitener: clock, reset, stimulus,
// receiver stalls and the verdict. Checking is done in whitener_scoreboard.
// Depends on swx_pkg and the block's RTL.
module seeded_xorshift_byte_whitener_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swx_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [63:0] value_i;
  logic        last_of_run_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  random_byte_o;
  logic        last_out_o;

  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_off;
  logic pressure_go;

  seeded_xorshift_byte_whitener dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .last_of_run_i (last_of_run_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_byte_o (random_byte_o),
    .last_out_o    (last_out_o)
  );

  whitener_scoreboard scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .last_of_run_i (last_of_run_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_byte_i (random_byte_o),
    .last_out_i    (last_out_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL seeded_xorshift_byte_whitener");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off so the output register fills and the input stalls.
  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input func_e f, input logic [63:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    value_i       <= v;
    last_of_run_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Mostly fill runs ended by last_of_run, with reseeds, mixes and noise between.
  task automatic random_phase(input int idle_pct, input int stall_pct, input int items);
    int sent;
    int pick;
    int run_len;
    logic last;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        offer(FUNC_RESEED, pick_value(), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 18) begin
        offer(FUNC_MIX, pick_value(), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 21) begin
        offer(FUNC_NONE, pick_value(), 1'($urandom_range(1)));
      end
      run_len = $urandom_range(1, 12);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(99) < 4) begin
          offer(FUNC_MIX, pick_value(), 1'b0);
          sent++;
        end
        if (k == run_len - 1) last = ($urandom_range(9) != 0);
        else last = ($urandom_range(29) == 0);
        offer(FUNC_BYTE, pick_value(), last);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_NONE;
    value_i        = '0;
    last_of_run_i  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase wrap from the reset seeds
    repeat (5) offer(FUNC_BYTE, '0, 1'b0);
    offer(FUNC_BYTE, '1, 1'b1);
    // flag ignored on reseed
    offer(FUNC_RESEED, '0, 1'b1);
    repeat (2) offer(FUNC_BYTE, '0, 1'b0);
    // mix in the middle of a run keeps the old word
    offer(FUNC_MIX, '1, 1'b1);
    repeat (2) offer(FUNC_BYTE, '0, 1'b0);
    offer(FUNC_NONE, '1, 1'b1);
    offer(FUNC_BYTE, '0, 1'b1);
    offer(FUNC_RESEED, '1, 1'b0);
    offer(FUNC_MIX, '0, 1'b0);
    offer(FUNC_MIX, 64'h8000_0000_0000_0001, 1'b0);
    repeat (4) offer(FUNC_BYTE, '1, 1'b0);
    offer(FUNC_BYTE, '0, 1'b1);

    pressure_go <= 1'b1;
    random_phase(0, 0, 480);
    random_phase(69, 0, 475);
    random_phase(0, 69, 475);
    random_phase(34, 34, 475);

    in_valid_i     <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS seeded_xorshift_byte_whitener");
    end else begin
      $display("FAIL seeded_xorshift_byte_whitener");
    end
    $finish;
  end

endmodule

/* seeded_xorshift_byte_whitener.f */
+incdir+rtl
rtl/swx_pkg.sv
rtl/swx_ctrl.sv
rtl/swx_dp.sv
rtl/seeded_xorshift_byte_whitener.sv
rtl/swx_chk.sv
tb/whitener_scoreboard.sv
tb/seeded_xorshift_byte_whitener_tb.sv
